FILE: design/thp_pkg.sv
package thp_pkg;

    localparam int KEY_MAX    = 32;
    localparam int VALUE_MAX  = 128;
    localparam int UID_MAX    = 16;
    localparam int CLASS_MAX  = 64;
    localparam int SOURCE_MAX = 128;
    localparam int TARGET_MAX = 128;

    localparam logic [6:0] HB_MASK  = 7'h5F;
    localparam logic [6:0] BSC_MASK = 7'h3F;
    localparam logic [2:0] NO_FIELD = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEAD, PH_PREFIX, PH_KEY, PH_VALUE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHAR, KIND_END, KIND_ACCEPT, KIND_REJECT
    } kind_t;

    typedef enum logic [2:0] {
        CAUSE_NONE, CAUSE_OPENING, CAUSE_KEY_LONG, CAUSE_VALUE_LONG,
        CAUSE_EARLY, CAUSE_INCONSISTENT
    } cause_t;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       first_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  field_sel;
        logic [7:0]  value_char;
        logic [15:0] version_num;
        logic [15:0] hop_count;
        logic [15:0] interval_num;
        logic        is_heartbeat;
        logic [6:0]  present_mask;
        logic [2:0]  reject_cause;
    } out_item_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] open_char(input logic b, input logic [3:0] p);
        string s;
        s = b ? "xap-hbeat\n{\n" : "xap-header\n{\n";
        return (int'(p) < s.len()) ? 8'(s[p]) : 8'h00;
    endfunction

    function automatic logic [3:0] open_len(input logic b);
        return b ? 4'd12 : 4'd13;
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [5:0] p);
        string s;
        unique case (k)
            3'd0: s = "v";
            3'd1: s = "hop";
            3'd2: s = "uid";
            3'd3: s = "class";
            3'd4: s = "source";
            3'd5: s = "target";
            default: s = "interval";
        endcase
        return (int'(p) < s.len()) ? 8'(s[p]) : 8'h00;
    endfunction

    function automatic logic [3:0] key_size(input logic [2:0] k);
        unique case (k)
            3'd0: return 4'd1;
            3'd1: return 4'd3;
            3'd2: return 4'd3;
            3'd3: return 4'd5;
            3'd4: return 4'd6;
            3'd5: return 4'd6;
            default: return 4'd8;
        endcase
    endfunction

    function automatic logic [7:0] class_char(input logic [1:0] k, input logic [7:0] p);
        string s;
        unique case (k)
            2'd0: s = "xap-hbeat.alive";
            2'd1: s = "xapbsc.cmd";
            2'd2: s = "xapbsc.query";
            default: s = "xap-x10.request";
        endcase
        return (int'(p) < s.len()) ? 8'(s[p]) : 8'h00;
    endfunction

    function automatic logic [3:0] class_size(input logic [1:0] k);
        unique case (k)
            2'd0: return 4'd15;
            2'd1: return 4'd10;
            2'd2: return 4'd12;
            default: return 4'd15;
        endcase
    endfunction

    function automatic logic [8:0] field_limit(input logic [2:0] f);
        int lim;
        lim = VALUE_MAX;
        unique case (f)
            3'd2: lim = (UID_MAX < VALUE_MAX) ? UID_MAX : VALUE_MAX;
            3'd3: lim = (CLASS_MAX < VALUE_MAX) ? CLASS_MAX : VALUE_MAX;
            3'd4: lim = (SOURCE_MAX < VALUE_MAX) ? SOURCE_MAX : VALUE_MAX;
            3'd5: lim = (TARGET_MAX < VALUE_MAX) ? TARGET_MAX : VALUE_MAX;
            default: lim = VALUE_MAX;
        endcase
        return 9'(lim);
    endfunction

endpackage

FILE: design/thp_num.sv
module thp_num
    import thp_pkg::*;
(
    input  logic [15:0] acc,
    input  logic [1:0]  stage,
    input  logic        neg,
    input  logic [7:0]  c,
    output logic [15:0] acc_next,
    output logic [1:0]  stage_next,
    output logic        neg_next
);

    logic [19:0] prod;
    logic        blank;
    logic        digit;

    always_comb
    begin
        blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
        digit = (c >= 8'h30) && (c <= 8'h39);
        prod = {acc, 3'b000} + {3'b000, acc, 1'b0} + {12'd0, c - 8'h30};
        acc_next = acc;
        stage_next = stage;
        neg_next = neg;
        if (stage == 2'd0 && blank)
        begin
            stage_next = 2'd0;
        end
        else if (stage == 2'd0 && (c == 8'h2B || c == 8'h2D))
        begin
            neg_next = (c == 8'h2D);
            stage_next = 2'd1;
        end
        else if (stage != 2'd2)
        begin
            if (digit)
            begin
                acc_next = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
                stage_next = 2'd1;
            end
            else
            begin
                stage_next = 2'd2;
            end
        end
    end

endmodule

FILE: design/text_header_parser_top.sv
// text_header_parser_top: byte-serial header parser for home-automation messages.
// Input channel: in_valid / in_stall carry in_item (msg_byte, first_byte,
// final_byte). A transfer happens when valid is high and stall is low.
// Output channel: out_valid / out_stall carry out_item; each byte yields zero
// or one result (value byte, value end, accept or reject verdict).
// A result is registered and appears in the cycle after its byte's transfer.
// Throughput: one byte per cycle while in_stall is low; all parsing is one
// combinational step between the parser state registers and the output register.
// A stalled output holds its payload; in_stall follows out_stall only while
// the output register is full, so a free register keeps the input flowing.
// Reset clears the parser to idle; bytes are ignored until a first byte.
// A first byte drops any message in progress without a result.
module text_header_parser_top
    import thp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  ppos_reg, ppos_next;
    logic [1:0]  palive_reg, palive_next;
    logic [5:0]  klen_reg, klen_next;
    logic [6:0]  kmatch_reg, kmatch_next;
    logic [7:0]  vlen_reg, vlen_next;
    logic [2:0]  field_reg, field_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  nstage_reg, nstage_next;
    logic        nneg_reg, nneg_next;
    logic [15:0] ver_reg, ver_next;
    logic [15:0] hop_reg, hop_next;
    logic [15:0] intv_reg, intv_next;
    logic [6:0]  seen_reg, seen_next;
    logic        hb_reg, hb_next;
    logic [3:0]  cmatch_reg, cmatch_next;
    logic [3:0]  ctry_reg, ctry_next;
    logic        lstart_reg, lstart_next;
    logic        oval_reg;
    out_item_t   out_reg, res;
    logic        res_valid;
    logic        take;

    logic [15:0] nacc;
    logic [1:0]  nstg;
    logic        nng;

    thp_num u_num (
        .acc(acc_reg), .stage(nstage_reg), .neg(nneg_reg), .c(in_item.msg_byte),
        .acc_next(nacc), .stage_next(nstg), .neg_next(nng)
    );

    assign in_stall  = oval_reg && out_stall;
    assign take      = in_valid && !in_stall;
    assign out_valid = oval_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        logic [7:0] c;
        logic [7:0] lc;
        logic       done;
        logic [1:0] keep2;
        logic [6:0] keep7;
        logic [3:0] keep4;
        logic [2:0] cause;
        logic [2:0] f;
        logic [15:0] num;
        c = in_item.msg_byte;
        lc = to_lower(c);
        done = 1'b0;
        cause = CAUSE_NONE;
        keep2 = '0;
        keep7 = '0;
        keep4 = '0;
        num = '0;
        res_valid = 1'b0;
        res = '0;
        phase_next = phase_reg; ppos_next = ppos_reg; palive_next = palive_reg;
        klen_next = klen_reg; kmatch_next = kmatch_reg; vlen_next = vlen_reg;
        field_next = field_reg; acc_next = acc_reg; nstage_next = nstage_reg;
        nneg_next = nneg_reg; ver_next = ver_reg; hop_next = hop_reg;
        intv_next = intv_reg; seen_next = seen_reg; hb_next = hb_reg;
        cmatch_next = cmatch_reg; ctry_next = ctry_reg; lstart_next = lstart_reg;
        if (in_item.first_byte)
        begin
            phase_next = PH_LEAD; ppos_next = '0; palive_next = 2'b11;
            klen_next = '0; kmatch_next = 7'h7F; vlen_next = '0;
            field_next = NO_FIELD; acc_next = '0; nstage_next = '0; nneg_next = 1'b0;
            ver_next = '0; hop_next = '0; intv_next = '0; seen_next = '0;
            hb_next = 1'b0; cmatch_next = '0; ctry_next = '0; lstart_next = 1'b1;
        end
        f = field_next;
        unique case (phase_next)
            PH_IDLE:
            begin
            end
            PH_LEAD, PH_PREFIX:
            begin
                if (phase_next == PH_LEAD && c == 8'h0A)
                begin
                    phase_next = PH_PREFIX;
                end
                else
                begin
                    phase_next = PH_PREFIX;
                    for (int b = 0; b < 2; b++)
                    begin
                        if (palive_next[b] && ppos_next < open_len(b[0])
                            && lc == open_char(b[0], ppos_next))
                        begin
                            keep2[b] = 1'b1;
                        end
                    end
                    palive_next = keep2;
                    if (keep2 == 2'b00)
                    begin
                        done = 1'b1; cause = CAUSE_OPENING;
                    end
                    else if (keep2[1] && ppos_next + 4'd1 == open_len(1'b1))
                    begin
                        hb_next = 1'b1; phase_next = PH_KEY; lstart_next = 1'b1;
                        klen_next = '0; kmatch_next = 7'h7F;
                    end
                    else if (keep2[0] && ppos_next + 4'd1 == open_len(1'b0))
                    begin
                        hb_next = 1'b0; phase_next = PH_KEY; lstart_next = 1'b1;
                        klen_next = '0; kmatch_next = 7'h7F;
                    end
                    else
                    begin
                        ppos_next = ppos_next + 4'd1;
                    end
                end
            end
            PH_KEY:
            begin
                if (lstart_next && c == 8'h7D)
                begin
                    done = 1'b1;
                    if (hb_next)
                    begin
                        if (!cmatch_next[0] || seen_next != HB_MASK)
                            cause = CAUSE_INCONSISTENT;
                    end
                    else if (cmatch_next[3:1] != 3'b000 && seen_next != BSC_MASK)
                    begin
                        cause = CAUSE_INCONSISTENT;
                    end
                end
                else if (c == 8'h00)
                begin
                    done = 1'b1; cause = CAUSE_EARLY;
                end
                else if (c == 8'h3D)
                begin
                    field_next = NO_FIELD;
                    for (int k = 6; k >= 0; k--)
                    begin
                        if (kmatch_next[k] && klen_next == {2'b00, key_size(3'(k))})
                            field_next = 3'(k);
                    end
                    vlen_next = '0; acc_next = '0; nstage_next = '0; nneg_next = 1'b0;
                    ctry_next = 4'hF; phase_next = PH_VALUE;
                end
                else if ({1'b0, klen_next} + 7'd1 >= 7'(KEY_MAX))
                begin
                    done = 1'b1; cause = CAUSE_KEY_LONG;
                end
                else
                begin
                    for (int k = 0; k < 7; k++)
                    begin
                        if (kmatch_next[k] && klen_next < {2'b00, key_size(3'(k))}
                            && lc == key_char(3'(k), klen_next))
                            keep7[k] = 1'b1;
                    end
                    kmatch_next = keep7;
                    klen_next = klen_next + 6'd1;
                    lstart_next = 1'b0;
                end
            end
            default:
            begin
                if (c == 8'h00)
                begin
                    done = 1'b1; cause = CAUSE_EARLY;
                end
                else if (c == 8'h0A)
                begin
                    num = nneg_next ? 16'd0 : acc_next;
                    if (f == 3'd0) ver_next = num;
                    if (f == 3'd1) hop_next = num;
                    if (f == 3'd6) intv_next = num;
                    if (f == 3'd3)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            if (ctry_next[k] && vlen_next == {4'd0, class_size(2'(k))})
                                keep4[k] = 1'b1;
                        end
                        cmatch_next = keep4;
                    end
                    if (f != NO_FIELD) seen_next[f] = 1'b1;
                    if (f >= 3'd2 && f <= 3'd5)
                    begin
                        res_valid = 1'b1;
                        res.result_kind = KIND_END;
                        res.field_sel = 2'(f - 3'd2);
                    end
                    phase_next = PH_KEY; lstart_next = 1'b1; klen_next = '0;
                    kmatch_next = 7'h7F; field_next = NO_FIELD;
                end
                else if ({1'b0, vlen_next} + 9'd1 >= field_limit(f))
                begin
                    done = 1'b1; cause = CAUSE_VALUE_LONG;
                end
                else
                begin
                    if (f == 3'd0 || f == 3'd1 || f == 3'd6)
                    begin
                        acc_next = nacc; nstage_next = nstg; nneg_next = nng;
                    end
                    if (f == 3'd3)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            if (ctry_next[k] && vlen_next < {4'd0, class_size(2'(k))}
                                && lc == class_char(2'(k), vlen_next))
                                keep4[k] = 1'b1;
                        end
                        ctry_next = keep4;
                    end
                    vlen_next = vlen_next + 8'd1;
                    if (f >= 3'd2 && f <= 3'd5)
                    begin
                        res_valid = 1'b1;
                        res.result_kind = KIND_CHAR;
                        res.field_sel = 2'(f - 3'd2);
                        res.value_char = c;
                    end
                end
            end
        endcase
        if (!done && in_item.final_byte && phase_next != PH_IDLE)
        begin
            done = 1'b1;
            cause = (phase_next == PH_LEAD || phase_next == PH_PREFIX)
                    ? CAUSE_OPENING : CAUSE_EARLY;
        end
        if (done)
        begin
            res = '0;
            res_valid = 1'b1;
            res.result_kind = (cause != CAUSE_NONE) ? KIND_REJECT : KIND_ACCEPT;
            res.version_num = ver_next;
            res.hop_count = hop_next;
            res.interval_num = intv_next;
            res.is_heartbeat = hb_next;
            res.present_mask = seen_next;
            res.reject_cause = cause;
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; ppos_reg <= '0; palive_reg <= 2'b11;
            klen_reg <= '0; kmatch_reg <= 7'h7F; vlen_reg <= '0;
            field_reg <= NO_FIELD; acc_reg <= '0; nstage_reg <= '0; nneg_reg <= 1'b0;
            ver_reg <= '0; hop_reg <= '0; intv_reg <= '0; seen_reg <= '0;
            hb_reg <= 1'b0; cmatch_reg <= '0; ctry_reg <= '0; lstart_reg <= 1'b1;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next; ppos_reg <= ppos_next; palive_reg <= palive_next;
                klen_reg <= klen_next; kmatch_reg <= kmatch_next; vlen_reg <= vlen_next;
                field_reg <= field_next; acc_reg <= acc_next; nstage_reg <= nstage_next;
                nneg_reg <= nneg_next; ver_reg <= ver_next; hop_reg <= hop_next;
                intv_reg <= intv_next; seen_reg <= seen_next; hb_reg <= hb_next;
                cmatch_reg <= cmatch_next; ctry_reg <= ctry_next; lstart_reg <= lstart_next;
            end
            if (take)
                oval_reg <= res_valid;
            else if (!out_stall)
                oval_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
            out_reg <= res;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output changed under stall");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == PH_IDLE && !in_item.first_byte |=> !out_valid)
        else $error("result from idle parser");
    a_verdict_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && res_valid && (res.result_kind == KIND_ACCEPT || res.result_kind == KIND_REJECT)
        |=> phase_reg == PH_IDLE)
        else $error("verdict without return to idle");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import thp_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    text_header_parser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam int         FLD_NONE = 7;

    // parser copy
    phase_t      p_phase;
    int          p_pos;
    logic [1:0]  p_alive;
    int          p_klen;
    logic [6:0]  p_kmatch;
    int          p_vlen;
    int          p_field;
    int          p_acc;
    logic [15:0] p_ver;
    logic [15:0] p_hop;
    logic [15:0] p_ivl;
    logic [6:0]  p_seen;
    logic        p_hb;
    logic [3:0]  p_cls;
    logic [3:0]  p_ctry;
    logic        p_lstart;
    int          p_nstage;
    logic        p_neg;

    string open_s[2]  = '{"xap-header\n{\n", "xap-hbeat\n{\n"};
    string key_s[7]   = '{"v", "hop", "uid", "class", "source", "target", "interval"};
    string class_s[4] = '{"xap-hbeat.alive", "xapbsc.cmd", "xapbsc.query",
                          "xap-x10.request"};

    // directed row: head text, then one byte carrying the expectation
    typedef struct {
        string      head;
        logic       head_first;
        logic [7:0] c;
        logic       c_first;
        logic       c_last;
        logic       check;
        kind_t      kind;
        cause_t     cause;
    } row_t;

    row_t      rows[$];
    out_item_t pending_results[$];
    int        errors;
    int        sent;
    logic      idle_free;

    function automatic logic [7:0] lc(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic string rep(string s, int n);
        string o;
        o = "";
        for (int i = 0; i < n; i++)
            o = {o, s};
        return o;
    endfunction

    function automatic int limit_of(int f);
        int lim;
        lim = VALUE_MAX;
        case (f)
            2: lim = UID_MAX;
            3: lim = CLASS_MAX;
            4: lim = SOURCE_MAX;
            5: lim = TARGET_MAX;
            default: lim = VALUE_MAX;
        endcase
        return (lim < VALUE_MAX) ? lim : VALUE_MAX;
    endfunction

    task automatic clear_parser();
        p_pos = 0; p_alive = 2'b11; p_klen = 0; p_kmatch = 7'h7F; p_vlen = 0;
        p_field = FLD_NONE; p_acc = 0; p_ver = 0; p_hop = 0; p_ivl = 0;
        p_seen = 0; p_hb = 0; p_cls = 0; p_ctry = 0; p_lstart = 1;
        p_nstage = 0; p_neg = 0;
    endtask

    function automatic out_item_t verdict(cause_t cause);
        out_item_t r;
        r = '0;
        r.result_kind  = (cause == CAUSE_NONE) ? KIND_ACCEPT : KIND_REJECT;
        r.version_num  = p_ver;
        r.hop_count    = p_hop;
        r.interval_num = p_ivl;
        r.is_heartbeat = p_hb;
        r.present_mask = p_seen;
        r.reject_cause = cause;
        return r;
    endfunction

    function automatic out_item_t value_item(kind_t k, int f, logic [7:0] c);
        out_item_t r;
        r = '0;
        r.result_kind = k;
        r.field_sel   = 2'(f - 2);
        r.value_char  = c;
        return r;
    endfunction

    task automatic take_number(logic [7:0] c);
        if (p_nstage == 0)
        begin
            if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D)
                return;
            if (c == "+" || c == "-")
            begin
                p_neg = (c == "-");
                p_nstage = 1;
                return;
            end
            p_nstage = 1;
        end
        if (p_nstage == 1)
        begin
            if (c >= "0" && c <= "9")
            begin
                p_acc = p_acc * 10 + int'(c - "0");
                if (p_acc > 65535)
                    p_acc = 65535;
            end
            else
                p_nstage = 2;
        end
    endtask

    // returns 1 and fills r when the byte yields a result
    task automatic parse_byte(in_item_t it, output logic got, output out_item_t r);
        logic [7:0] c;
        logic [1:0] keep2;
        logic [6:0] keep7;
        logic [3:0] keep4;
        logic       done;
        int         f;
        int         num;
        c = it.msg_byte;
        got = 0;
        r = '0;
        done = 0;
        if (it.first_byte)
        begin
            clear_parser();
            p_phase = PH_LEAD;
        end
        if (p_phase == PH_IDLE)
            return;
        if (p_phase == PH_LEAD || p_phase == PH_PREFIX)
        begin
            if (p_phase == PH_LEAD && c == CH_NL)
                p_phase = PH_PREFIX;
            else
            begin
                p_phase = PH_PREFIX;
                keep2 = 0;
                for (int b = 0; b < 2; b++)
                    if (p_alive[b] && p_pos < open_s[b].len() && lc(c) == open_s[b][p_pos])
                        keep2[b] = 1;
                p_alive = keep2;
                if (keep2 == 0)
                begin
                    r = verdict(CAUSE_OPENING); got = 1; p_phase = PH_IDLE;
                    return;
                end
                for (int b = 0; b < 2; b++)
                    if (!done && keep2[b] && p_pos + 1 == open_s[b].len())
                    begin
                        p_hb = b[0]; p_phase = PH_KEY; p_lstart = 1;
                        p_klen = 0; p_kmatch = 7'h7F; done = 1;
                    end
                if (!done)
                    p_pos = (p_pos + 1) & 15;
            end
        end
        else if (p_phase == PH_KEY)
        begin
            if (p_lstart && c == CH_CLOSE)
            begin
                cause_t cz;
                cz = CAUSE_NONE;
                if (p_hb)
                begin
                    if (!p_cls[0] || p_seen != HB_MASK)
                        cz = CAUSE_INCONSISTENT;
                end
                else if (p_cls[3:1] != 0 && p_seen != BSC_MASK)
                    cz = CAUSE_INCONSISTENT;
                r = verdict(cz); got = 1; p_phase = PH_IDLE;
                return;
            end
            else if (c == 0)
            begin
                r = verdict(CAUSE_EARLY); got = 1; p_phase = PH_IDLE;
                return;
            end
            else if (c == CH_EQ)
            begin
                p_field = FLD_NONE;
                for (int k = 6; k >= 0; k--)
                    if (p_kmatch[k] && p_klen == key_s[k].len())
                        p_field = k;
                p_vlen = 0; p_acc = 0; p_nstage = 0; p_neg = 0; p_ctry = 4'hF;
                p_phase = PH_VALUE;
            end
            else
            begin
                if (p_klen + 1 >= KEY_MAX)
                begin
                    r = verdict(CAUSE_KEY_LONG); got = 1; p_phase = PH_IDLE;
                    return;
                end
                keep7 = 0;
                for (int k = 0; k < 7; k++)
                    if (p_kmatch[k] && p_klen < key_s[k].len() && lc(c) == key_s[k][p_klen])
                        keep7[k] = 1;
                p_kmatch = keep7;
                p_klen = p_klen + 1;
                p_lstart = 0;
            end
        end
        else
        begin
            f = p_field;
            if (c == 0)
            begin
                r = verdict(CAUSE_EARLY); got = 1; p_phase = PH_IDLE;
                return;
            end
            else if (c == CH_NL)
            begin
                num = p_neg ? 0 : p_acc;
                if (f == 0) p_ver = 16'(num);
                else if (f == 1) p_hop = 16'(num);
                else if (f == 6) p_ivl = 16'(num);
                else if (f == 3)
                begin
                    keep4 = 0;
                    for (int k = 0; k < 4; k++)
                        if (p_ctry[k] && p_vlen == class_s[k].len())
                            keep4[k] = 1;
                    p_cls = keep4;
                end
                if (f < 7) p_seen[f] = 1;
                if (f >= 2 && f <= 5)
                begin
                    r = value_item(KIND_END, f, 8'h00); got = 1;
                end
                p_phase = PH_KEY; p_lstart = 1; p_klen = 0; p_kmatch = 7'h7F;
                p_field = FLD_NONE;
            end
            else
            begin
                if (p_vlen + 1 >= limit_of(f))
                begin
                    r = verdict(CAUSE_VALUE_LONG); got = 1; p_phase = PH_IDLE;
                    return;
                end
                if (f == 0 || f == 1 || f == 6)
                    take_number(c);
                if (f == 3)
                begin
                    keep4 = 0;
                    for (int k = 0; k < 4; k++)
                        if (p_ctry[k] && p_vlen < class_s[k].len()
                            && lc(c) == class_s[k][p_vlen])
                            keep4[k] = 1;
                    p_ctry = keep4;
                end
                p_vlen = p_vlen + 1;
                if (f >= 2 && f <= 5)
                begin
                    r = value_item(KIND_CHAR, f, c); got = 1;
                end
            end
        end
        if (it.final_byte && p_phase != PH_IDLE)
        begin
            r = verdict((p_phase == PH_LEAD || p_phase == PH_PREFIX) ?
                        CAUSE_OPENING : CAUSE_EARLY);
            got = 1;
            p_phase = PH_IDLE;
        end
    endtask

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = pending_results.pop_front();
                if (e !== out_item)
                begin
                    $display("%0t: result mismatch, expected %p, actual %p", $time, e, out_item);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 0;
        else
            out_stall <= idle_free ? 1'b0 : ($urandom_range(99) < 9);
    end

    // stimulus sent one transfer at a time, with an optional directed expectation
    task automatic send(logic [7:0] c, logic fb, logic lb, logic check_kind = 0,
                        kind_t kind = KIND_CHAR, logic check_cause = 0,
                        cause_t cause = CAUSE_NONE);
        in_item_t  it;
        logic      got;
        out_item_t r;
        it.msg_byte = c; it.first_byte = fb; it.final_byte = lb;
        while (!idle_free && $urandom_range(99) < 9)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent = sent + 1;
        parse_byte(it, got, r);
        if (check_kind && (!got || r.result_kind != kind
            || (check_cause && r.reject_cause != cause)))
        begin
            $display("%0t: directed mismatch, expected kind %s cause %s, actual %p",
                     $time, kind.name(), cause.name(), r);
            errors++;
        end
        if (got)
            pending_results.push_back(r);
        @(negedge clk);
    endtask

    task automatic send_text(string s, logic first, logic last_on_end);
        for (int i = 0; i < s.len(); i++)
            send(s[i], first && i == 0, last_on_end && i == s.len() - 1);
    endtask

    function automatic string rand_case(string s);
        string o;
        o = s;
        for (int i = 0; i < o.len(); i++)
            if (o[i] >= "a" && o[i] <= "z" && $urandom_range(1))
                o[i] = o[i] - 8'd32;
        return o;
    endfunction

    function automatic string rand_value(int f);
        string o;
        int    n;
        int    pick;
        o = "";
        pick = $urandom_range(9);
        if (f == 3 && pick < 6)
            return rand_case(class_s[$urandom_range(3)]);
        if ((f == 0 || f == 1 || f == 6) && pick < 8)
        begin
            if ($urandom_range(3) == 0) o = {o, " "};
            if ($urandom_range(4) == 0) o = {o, ($urandom_range(1) ? "-" : "+")};
            n = $urandom_range(1, $urandom_range(4) == 0 ? 7 : 4);
            for (int i = 0; i < n; i++)
                o = {o, string'(8'("0" + $urandom_range(9)))};
            if ($urandom_range(5) == 0) o = {o, "x9"};
            return o;
        end
        n = ($urandom_range(19) == 0) ? $urandom_range(limit_of(f) - 2, limit_of(f) + 1)
                                      : $urandom_range(0, 12);
        for (int i = 0; i < n; i++)
        begin
            byte ch;
            ch = 8'($urandom_range(1, 255));
            if (ch == CH_NL) ch = "a";
            o = {o, string'(ch)};
        end
        return o;
    endfunction

    task automatic rand_message();
        int    lines;
        int    k;
        string key;
        logic  hb;
        logic  lead;
        hb = $urandom_range(2) == 0;
        lead = $urandom_range(9) == 0;
        if (lead)
            send(CH_NL, 1, 0);
        send_text(rand_case(open_s[hb]), !lead, 0);
        lines = $urandom_range(0, 9);
        if (hb)
        begin
            for (int i = 0; i < 7; i++)
                if (i != 5 && $urandom_range(9) != 0)
                begin
                    send_text({rand_case(key_s[i]), "=",
                               i == 3 ? "xap-hbeat.alive" : rand_value(i), "\n"}, 0, 0);
                end
        end
        for (int i = 0; i < lines; i++)
        begin
            k = $urandom_range(9);
            if (k < 7) key = rand_case(key_s[k]);
            else if (k == 7) key = "";
            else if (k == 8) key = {"zz", key_s[$urandom_range(6)]};
            else
            begin
                key = "";
                for (int j = 0; j < $urandom_range(20, 34); j++)
                    key = {key, "k"};
            end
            send_text({key, "=", rand_value(k < 7 ? k : 4), "\n"}, 0, 0);
            if (p_phase == PH_IDLE) break;
        end
        case ($urandom_range(9))
            0: send(8'h00, 0, 0);
            1: send("q", 0, 1);
            2: send(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
            default: send(CH_CLOSE, 0, 1'($urandom_range(1)));
        endcase
        if ($urandom_range(3) == 0)
            send(8'($urandom_range(255)), 0, 1'($urandom_range(1)));
    endtask

    initial
    begin
        errors    = 0;
        idle_free = 0;
        sent      = 0;
        rst_n     = 0;
        in_valid  = 0;
        in_item   = '0;
        out_stall = 0;
        clear_parser();
        p_phase = PH_IDLE;

        // ignored while idle, then openings
        rows.push_back(row_t'{"", 0, 8'hFF, 0, 1, 0, KIND_CHAR, CAUSE_NONE});
        rows.push_back(row_t'{"", 0, "Q", 1, 0, 1, KIND_REJECT, CAUSE_OPENING});
        rows.push_back(row_t'{"", 0, CH_NL, 1, 0, 0, KIND_CHAR, CAUSE_NONE});
        rows.push_back(row_t'{"", 0, CH_NL, 0, 0, 1, KIND_REJECT, CAUSE_OPENING});
        rows.push_back(row_t'{"", 0, "x", 1, 1, 1, KIND_REJECT, CAUSE_OPENING});
        rows.push_back(row_t'{"", 0, "X", 1, 0, 0, KIND_CHAR, CAUSE_NONE});
        rows.push_back(row_t'{"", 0, 8'h00, 0, 0, 1, KIND_REJECT, CAUSE_OPENING});
        rows.push_back(row_t'{"XAP-HBEAT\n{\n", 1, CH_CLOSE, 0, 0, 1, KIND_REJECT,
                              CAUSE_INCONSISTENT});
        rows.push_back(row_t'{"\nxap-header\n{\n", 1, CH_CLOSE, 0, 0, 1, KIND_ACCEPT,
                              CAUSE_NONE});
        rows.push_back(row_t'{{"xap-header\n{\nv=99999999\nhop=-3\ninterval= +65535\n",
                               "uid=FF\nclass=xAPBSC.cmd\nsource=a\ntarget=b\nuid=1\n"},
                              1, CH_CLOSE, 0, 0, 0, KIND_CHAR, CAUSE_NONE});
        rows.push_back(row_t'{"xap-header\n{\nclass=XAP-X10.REQUEST\n", 1, CH_CLOSE, 0, 0,
                              1, KIND_REJECT, CAUSE_INCONSISTENT});
        rows.push_back(row_t'{{"xap-header\n{\n", rep("k", KEY_MAX - 1)}, 1, "k", 0, 0,
                              1, KIND_REJECT, CAUSE_KEY_LONG});
        rows.push_back(row_t'{{"xap-header\n{\nuid=", rep("u", UID_MAX - 1)}, 1, "z", 0, 0,
                              1, KIND_REJECT, CAUSE_VALUE_LONG});
        rows.push_back(row_t'{{"xap-header\n{\nzz=", rep("v", VALUE_MAX - 1)}, 1, "v", 0, 0,
                              1, KIND_REJECT, CAUSE_VALUE_LONG});
        rows.push_back(row_t'{"xap-header\n{\nsource=ab", 1, 8'h00, 0, 0, 1, KIND_REJECT,
                              CAUSE_EARLY});
        rows.push_back(row_t'{"xap-header\n{\nkey", 1, CH_EQ, 0, 1, 1, KIND_REJECT,
                              CAUSE_EARLY});
        rows.push_back(row_t'{"xap-header\n{\nv", 1, "x", 1, 0, 0, KIND_CHAR, CAUSE_NONE});
        rows.push_back(row_t'{"", 0, "y", 0, 0, 1, KIND_REJECT, CAUSE_OPENING});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (rows[i])
        begin
            if (rows[i].head.len() != 0)
                send_text(rows[i].head, rows[i].head_first, 0);
            send(rows[i].c, rows[i].c_first, rows[i].c_last, rows[i].check,
                 rows[i].kind, rows[i].check, rows[i].cause);
        end

        // random messages, mostly well formed, with a quiet stretch
        for (int m = 0; sent < 1650 && m < 100000; m++)
        begin
            idle_free = (m >= 4 && m < 9);
            if ($urandom_range(14) == 0)
            begin
                in_item_t it;
                it = in_item_t'(10'($urandom));
                send(it.msg_byte, it.first_byte, it.final_byte);
            end
            else
                rand_message();
        end
        idle_free = 0;
        in_valid <= 0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: text_header_parser_top.f
design/thp_pkg.sv
design/thp_num.sv
design/text_header_parser_top.sv
tb/sv/tb.sv
